@@ design/cross_peak_clip_filter_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the cross peak clip filter
// Concurrent checks on clk, disabled while rst_n is low; empty when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef CROSS_PEAK_CLIP_FILTER_DEFINES_SVH
`define CROSS_PEAK_CLIP_FILTER_DEFINES_SVH

`ifndef SYNTH

// cond holds in the same cycle as trig
`define CPCF_ASSERT_IMP(label, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error("cpcf check failed");

// cond holds in the cycle after trig
`define CPCF_ASSERT_NXT(label, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("cpcf check failed");

`else

`define CPCF_ASSERT_IMP(label, trig, cond)
`define CPCF_ASSERT_NXT(label, trig, cond)

`endif

`endif

@@ design/cpcf_pkg.sv @@
// ----------------------------------------------------------------------------
// cpcf_pkg
// Register codes, field widths and stage flag type of the cross peak clip filter.
// ----------------------------------------------------------------------------
`default_nettype none

package cpcf_pkg;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam int COLS_W     = 11;
    localparam int ROWS_W     = 16;
    localparam int RES_CNT_W  = 2;

    localparam logic [COLS_W-1:0] COLS_RESET = 11'd1024;
    localparam logic [ROWS_W-1:0] ROWS_RESET = 16'd1024;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_COLS = 1'b0,
        REG_FRAME_ROWS = 1'b1
    } cfg_reg_t;

    // position facts of one pixel, worked out when it is accepted
    typedef struct packed {
        logic a_en;      // row above exists: emit the pixel above
        logic a_up_v;    // pixel above has its own upper neighbor
        logic left_v;    // column >= 1
        logic left2_v;   // column >= 2
        logic right_v;   // not the last column
        logic last_row;  // pixel is in the last row
        logic col_last;  // pixel is in the last column
    } stage_flags_t;

endpackage

`default_nettype wire

@@ design/cross_peak_clip_filter.sv @@
// ----------------------------------------------------------------------------
// cross_peak_clip_filter
// Four-neighbor local maximum clip on a raster pixel stream.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall, pixel_in): one pixel word per accept,
//   raster order. Output channel (out_valid / out_stall, pixel_out, row_end,
//   frame_end): each pixel clipped to the largest of its in-frame up, down,
//   left and right neighbors, in raster order. Row r-1 comes out while row r
//   streams in; the last row drains as it arrives.
//   A pixel's words pass through the stage register, then the result register.
//   A config write is followed by an input stall that refetches the line word.
//   Throughput: one word per cycle while out_stall is low, set by one result
//   word out and one line store read and write per pixel. In the last row a
//   pixel can yield up to three words; they drain one per cycle, out_stall
//   permitting, while the input stalls.
//   Reset: sizes go to 1024 x 1024, position to row 0 column 0, no result
//   pending; line stores are not cleared. Output stall holds the result
//   register and backs up into in_stall combinationally.
// ----------------------------------------------------------------------------
`default_nettype none
`include "cross_peak_clip_filter_defines.svh"

module cross_peak_clip_filter
    import cpcf_pkg::*;
#(
    parameter int MAX_COLS   = 1024,
    parameter int PIXEL_BITS = 16
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,

    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [PIXEL_BITS-1:0] pixel_in,

    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [PIXEL_BITS-1:0]      pixel_out,
    output logic                       row_end,
    output logic                       frame_end
);

    localparam int COL_W = $clog2(MAX_COLS);
    localparam int EW    = (COL_W + 1 > COLS_W) ? COL_W + 1 : COLS_W;
    localparam logic [EW-1:0]    MAX_COLS_E   = EW'(MAX_COLS);
    localparam logic [COL_W-1:0] LAST_COL_MAX = COL_W'(MAX_COLS - 1);

    // one line store word per column: upper row in the high half
    typedef struct packed {
        logic [PIXEL_BITS-1:0] upper;
        logic [PIXEL_BITS-1:0] middle;
    } line_word_t;

    typedef struct packed {
        logic [PIXEL_BITS-1:0] pix;
        logic                  row_end;
        logic                  frame_end;
    } res_t;

    // smaller of center and largest valid neighbor; no neighbor passes center
    function automatic logic [PIXEL_BITS-1:0] clip_px(
        input logic [PIXEL_BITS-1:0] ctr,
        input logic [3:0]            vld,
        input logic [PIXEL_BITS-1:0] n0,
        input logic [PIXEL_BITS-1:0] n1,
        input logic [PIXEL_BITS-1:0] n2,
        input logic [PIXEL_BITS-1:0] n3
    );
        logic [PIXEL_BITS-1:0] a0, a1, a2, a3, m01, m23, mx;
        a0  = vld[3] ? n0 : '0;
        a1  = vld[2] ? n1 : '0;
        a2  = vld[1] ? n2 : '0;
        a3  = vld[0] ? n3 : '0;
        m01 = (a0 > a1) ? a0 : a1;
        m23 = (a2 > a3) ? a2 : a3;
        mx  = (m01 > m23) ? m01 : m23;
        if (vld == 4'b0000)
            clip_px = ctr;
        else
            clip_px = (mx < ctr) ? mx : ctr;
    endfunction

    // ------------------------------------------------------------------
    // config registers
    // ------------------------------------------------------------------
    logic [COLS_W-1:0] frame_cols_reg;
    logic [ROWS_W-1:0] frame_rows_reg;
    logic              cfg_hold_reg;   // bubble after a write: refetch line word

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_cols_reg <= COLS_RESET;
            frame_rows_reg <= ROWS_RESET;
            cfg_hold_reg   <= 1'b0;
        end
        else
        begin
            cfg_hold_reg <= cfg_we;
            if (cfg_we)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_FRAME_COLS: frame_cols_reg <= cfg_data[COLS_W-1:0];
                    REG_FRAME_ROWS: frame_rows_reg <= cfg_data[ROWS_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // effective last column / last row (zero size counts as one,
    // width above MAX_COLS is clamped)
    logic [EW-1:0]     fc_ext;
    logic [EW-1:0]     fc_m1;
    logic [COL_W-1:0]  last_col;
    logic [ROWS_W-1:0] last_row;

    always_comb
    begin
        fc_ext = EW'(frame_cols_reg);
        fc_m1  = fc_ext - 1'b1;
        if (frame_cols_reg == '0)
            last_col = '0;
        else if (fc_ext > MAX_COLS_E)
            last_col = LAST_COL_MAX;
        else
            last_col = fc_m1[COL_W-1:0];
        last_row = (frame_rows_reg == '0) ? '0 : frame_rows_reg - 1'b1;
    end

    // ------------------------------------------------------------------
    // position of the next pixel
    // ------------------------------------------------------------------
    logic [COL_W-1:0]  col_count_reg;
    logic [ROWS_W-1:0] row_count_reg;
    logic              col_wrap;
    logic [COL_W-1:0]  cur_col;
    logic [ROWS_W-1:0] row_inc;
    logic [ROWS_W-1:0] cur_row;
    logic              col_last;
    logic              row_last;
    logic [COL_W-1:0]  next_col;
    logic [ROWS_W-1:0] next_row;
    stage_flags_t      flags;

    always_comb
    begin
        // counters left past a smaller size wrap first
        col_wrap = (col_count_reg > last_col);
        cur_col  = col_wrap ? '0 : col_count_reg;
        row_inc  = col_wrap ? row_count_reg + 1'b1 : row_count_reg;
        cur_row  = (row_inc > last_row) ? '0 : row_inc;
        col_last = (cur_col == last_col);
        row_last = (cur_row == last_row);
        next_col = col_last ? '0 : cur_col + 1'b1;
        if (!col_last)
            next_row = cur_row;
        else if (row_last)
            next_row = '0;
        else
            next_row = cur_row + 1'b1;

        flags.a_en     = (cur_row != '0);
        flags.a_up_v   = (cur_row[ROWS_W-1:1] != '0);
        flags.left_v   = (cur_col != '0);
        flags.left2_v  = (cur_col > COL_W'(1));
        flags.right_v  = !col_last;
        flags.last_row = row_last;
        flags.col_last = col_last;
    end

    // ------------------------------------------------------------------
    // handshake
    // ------------------------------------------------------------------
    logic                 s_valid_reg;
    logic [RES_CNT_W-1:0] res_cnt_reg;
    logic                 out_take;
    logic                 bank_free;
    logic                 s_advance;
    logic                 in_accept;

    assign out_valid = (res_cnt_reg != '0);
    assign out_take  = out_valid && !out_stall;
    assign bank_free = (res_cnt_reg == '0) ||
                       ((res_cnt_reg == RES_CNT_W'(1)) && out_take);
    assign s_advance = s_valid_reg && bank_free;
    assign in_stall  = cfg_hold_reg || (s_valid_reg && !bank_free);
    assign in_accept = in_valid && !in_stall;

    // ------------------------------------------------------------------
    // line store: word c holds rows r-2 / r-1 for the pixel at column c.
    // rd_word_reg always holds the word of the next pixel's column; on
    // accept it is refilled with next_col (c+1, else 0), which is also the right
    // neighbor needed while that pixel sits in the stage register.
    // ------------------------------------------------------------------
    line_word_t       line_mem [MAX_COLS];
    line_word_t       rd_word_reg;
    line_word_t       wr_word;
    logic [COL_W-1:0] rd_addr;
    logic             rd_fwd;

    assign wr_word.upper  = rd_word_reg.middle;
    assign wr_word.middle = pixel_in;
    assign rd_addr        = in_accept ? next_col : cur_col;
    // single-column frame: next read hits the word written this cycle
    assign rd_fwd         = in_accept && (next_col == cur_col);

    always_ff @(posedge clk)
    begin
        if (in_accept)
            line_mem[cur_col] <= wr_word;
    end

    always_ff @(posedge clk)
    begin
        if (in_accept || cfg_hold_reg)
            rd_word_reg <= rd_fwd ? wr_word : line_mem[rd_addr];
    end

    // ------------------------------------------------------------------
    // position counters and row-r history
    // ------------------------------------------------------------------
    logic [PIXEL_BITS-1:0] held_left_reg;  // row r-1, column c-1
    logic [PIXEL_BITS-1:0] px1_reg;        // row r, column c-1
    logic [PIXEL_BITS-1:0] px2_reg;        // row r, column c-2

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg <= '0;
            row_count_reg <= '0;
            held_left_reg <= '0;
        end
        else if (in_accept)
        begin
            col_count_reg <= next_col;
            row_count_reg <= next_row;
            held_left_reg <= rd_word_reg.middle;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            px1_reg <= pixel_in;
            px2_reg <= px1_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage register
    // ------------------------------------------------------------------
    stage_flags_t          s_flags_reg;
    logic [PIXEL_BITS-1:0] s_px_reg;
    line_word_t            s_cur_reg;
    logic [PIXEL_BITS-1:0] s_left_reg;
    logic [PIXEL_BITS-1:0] s_px1_reg;
    logic [PIXEL_BITS-1:0] s_px2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s_valid_reg <= 1'b0;
        else if (in_accept)
            s_valid_reg <= 1'b1;
        else if (s_advance)
            s_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s_flags_reg <= flags;
            s_px_reg    <= pixel_in;
            s_cur_reg   <= rd_word_reg;
            s_left_reg  <= held_left_reg;
            s_px1_reg   <= px1_reg;
            s_px2_reg   <= px2_reg;
        end
    end

    // ------------------------------------------------------------------
    // results: A = pixel above (row r-1, col c); B = last row, col c-1;
    // C = last row, col c at the row end
    // ------------------------------------------------------------------
    res_t                 res_a;
    res_t                 res_b;
    res_t                 res_c;
    logic                 en_a;
    logic                 en_b;
    logic                 en_c;
    res_t                 slot0;
    res_t                 slot1;
    logic [RES_CNT_W-1:0] load_cnt;

    always_comb
    begin
        res_a.pix = clip_px(s_cur_reg.middle,
                            {s_flags_reg.a_up_v, 1'b1, s_flags_reg.left_v,
                             s_flags_reg.right_v},
                            s_cur_reg.upper, s_px_reg, s_left_reg,
                            rd_word_reg.middle);
        res_a.row_end   = s_flags_reg.col_last;
        res_a.frame_end = 1'b0;  // row r-1 is never the last row

        res_b.pix = clip_px(s_px1_reg,
                            {s_flags_reg.a_en, 1'b0, s_flags_reg.left2_v, 1'b1},
                            s_left_reg, '0, s_px2_reg, s_px_reg);
        res_b.row_end   = 1'b0;
        res_b.frame_end = 1'b0;

        res_c.pix = clip_px(s_px_reg,
                            {s_flags_reg.a_en, 1'b0, s_flags_reg.left_v, 1'b0},
                            s_cur_reg.middle, '0, s_px1_reg, '0);
        res_c.row_end   = 1'b1;
        res_c.frame_end = 1'b1;

        en_a = s_flags_reg.a_en;
        en_b = s_flags_reg.last_row && s_flags_reg.left_v;
        en_c = s_flags_reg.last_row && s_flags_reg.col_last;

        // pack the enabled results to the front, raster order kept
        slot0    = en_a ? res_a : (en_b ? res_b : res_c);
        slot1    = (en_a && en_b) ? res_b : res_c;
        load_cnt = {1'b0, en_a} + {1'b0, en_b} + {1'b0, en_c};
    end

    // ------------------------------------------------------------------
    // result register: three slots, drained from slot 0
    // ------------------------------------------------------------------
    res_t res_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_cnt_reg <= '0;
        else if (s_advance)
            res_cnt_reg <= load_cnt;
        else if (out_take)
            res_cnt_reg <= res_cnt_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (s_advance)
        begin
            res_reg[0] <= slot0;
            res_reg[1] <= slot1;
            res_reg[2] <= res_c;
        end
        else if (out_take)
        begin
            res_reg[0] <= res_reg[1];
            res_reg[1] <= res_reg[2];
        end
    end

    assign pixel_out = res_reg[0].pix;
    assign row_end   = res_reg[0].row_end;
    assign frame_end = res_reg[0].frame_end;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    `CPCF_ASSERT_NXT(a_cfg_bubble, cfg_we, !in_accept)
    `CPCF_ASSERT_IMP(a_frame_end_row_end, out_valid && frame_end, row_end)
    `CPCF_ASSERT_IMP(a_one_result_mid_frame, s_advance && !s_flags_reg.last_row, !load_cnt[1])

endmodule

`default_nettype wire
